// ===== hw/rtl/rcci_pkg.sv =====
// Package for the ray / capped cylinder intersection block.
// Holds item structs, register codes and width constants. No dependencies.
package rcci_pkg;

    localparam int CoordW   = 32;
    localparam int DistW    = 31;
    localparam int RegCount = 5;
    localparam int AddrW    = 5;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    // Item after the front end has centred it and formed the wall terms.
    typedef struct packed {
        logic        [64:0]  a;      // Dx^2 + Dz^2
        logic        [64:0]  bmag;   // |B|
        logic                b_pos;  // B > 0
        logic        [127:0] disc;   // A*R^2 - K^2
        logic                miss;   // discriminant too small
        logic signed [31:0]  oy;
        logic signed [31:0]  dy;
        logic signed [31:0]  cy;
        logic        [30:0]  h;
    } t_front_item;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
    } t_result;

endpackage

// ===== hw/rtl/rcci_front.sv =====
// Front end: centres the ray, forms A, B, K and the discriminant over
// registered multiply stages. Depends on rcci_pkg.
module rcci_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [31:0]       i_ox,
    input  logic signed [31:0]       i_oy,
    input  logic signed [31:0]       i_oz,
    input  logic signed [31:0]       i_dx,
    input  logic signed [31:0]       i_dy,
    input  logic signed [31:0]       i_dz,
    input  logic signed [31:0]       i_cx,
    input  logic signed [31:0]       i_cy,
    input  logic signed [31:0]       i_cz,
    input  logic        [30:0]       i_r,
    input  logic        [30:0]       i_h,
    output logic                     o_valid,
    output rcci_pkg::t_front_item    o_item
);
    import rcci_pkg::*;

    localparam int EpsRaw = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int EpsT   = (EpsRaw > 0) ? EpsRaw : 1;

    // stage 1: centre
    logic               r_v1;
    logic signed [32:0] r_ox1, r_oz1;
    logic signed [31:0] r_dx1, r_dz1, r_oy1, r_dy1, r_cy1;
    logic        [30:0] r_r1, r_h1;
    // stage 2: products
    logic               r_v2;
    logic signed [65:0] r_p, r_q, r_pb, r_qb;
    logic        [63:0] r_dxx, r_dzz;
    logic        [61:0] r_rr;
    logic signed [31:0] r_oy2, r_dy2, r_cy2;
    logic        [30:0] r_h2;
    // stage 3: sums
    logic               r_v3;
    logic        [64:0] r_a3, r_bmag3;
    logic        [63:0] r_k3;
    logic               r_bpos3;
    logic        [61:0] r_rr3;
    logic signed [31:0] r_oy3, r_dy3, r_cy3;
    logic        [30:0] r_h3;
    // stage 4: partial products of A*R^2 and K^2
    logic               r_v4;
    logic        [62:0] r_ar_ll, r_ar_lh, r_ar_hl, r_ar_hh;
    logic        [63:0] r_kk_ll, r_kk_lh, r_kk_hh;
    logic        [64:0] r_a4, r_bmag4;
    logic               r_bpos4;
    logic signed [31:0] r_oy4, r_dy4, r_cy4;
    logic        [30:0] r_h4;
    // stage 5: wide sums
    logic               r_v5;
    logic        [127:0] r_ar2, r_k2;
    logic        [64:0] r_a5, r_bmag5;
    logic               r_bpos5;
    logic signed [31:0] r_oy5, r_dy5, r_cy5;
    logic        [30:0] r_h5;

    logic signed [66:0] n_k, n_b;
    logic        [127:0] n_disc, n_eps;

    always_comb begin
        n_k = 67'(r_p) - 67'(r_q);
        n_b = 67'(r_pb) + 67'(r_qb);
        n_disc = r_ar2 - r_k2;
        n_eps = 128'(EpsT) << (3 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
            o_valid <= r_v5;
        end
        r_ox1 <= 33'(i_ox) - 33'(i_cx);
        r_oz1 <= 33'(i_oz) - 33'(i_cz);
        r_dx1 <= i_dx; r_dz1 <= i_dz; r_oy1 <= i_oy; r_dy1 <= i_dy;
        r_cy1 <= i_cy; r_r1 <= i_r; r_h1 <= i_h;

        r_p  <= 66'(r_dx1 * r_oz1);
        r_q  <= 66'(r_dz1 * r_ox1);
        r_pb <= 66'(r_dx1 * r_ox1);
        r_qb <= 66'(r_dz1 * r_oz1);
        r_dxx <= 64'(r_dx1 * r_dx1);
        r_dzz <= 64'(r_dz1 * r_dz1);
        r_rr <= r_r1 * r_r1;
        r_oy2 <= r_oy1; r_dy2 <= r_dy1; r_cy2 <= r_cy1; r_h2 <= r_h1;

        r_a3 <= 65'(r_dxx) + 65'(r_dzz);
        r_k3 <= n_k[66] ? 64'(-n_k) : 64'(n_k);
        r_bpos3 <= !n_b[66] && (n_b != '0);
        r_bmag3 <= n_b[66] ? 65'(-n_b) : 65'(n_b);
        r_rr3 <= r_rr;
        r_oy3 <= r_oy2; r_dy3 <= r_dy2; r_cy3 <= r_cy2; r_h3 <= r_h2;

        // A and K stay below 2^64: split into 32-bit halves, R^2 into 31-bit halves
        r_ar_ll <= 63'(r_a3[31:0] * r_rr3[30:0]);
        r_ar_lh <= 63'(r_a3[31:0] * r_rr3[61:31]);
        r_ar_hl <= 63'(r_a3[63:32] * r_rr3[30:0]);
        r_ar_hh <= 63'(r_a3[63:32] * r_rr3[61:31]);
        r_kk_ll <= 64'(r_k3[31:0] * r_k3[31:0]);
        r_kk_lh <= 64'(r_k3[31:0] * r_k3[63:32]);
        r_kk_hh <= 64'(r_k3[63:32] * r_k3[63:32]);
        r_a4 <= r_a3; r_bmag4 <= r_bmag3; r_bpos4 <= r_bpos3;
        r_oy4 <= r_oy3; r_dy4 <= r_dy3; r_cy4 <= r_cy3; r_h4 <= r_h3;

        r_ar2 <= 128'(r_ar_ll) + (128'(r_ar_lh) << 31) + (128'(r_ar_hl) << 32)
               + (128'(r_ar_hh) << 63);
        // cross term counted twice
        r_k2  <= 128'(r_kk_ll) + (128'(r_kk_lh) << 33) + (128'(r_kk_hh) << 64);
        r_a5 <= r_a4; r_bmag5 <= r_bmag4; r_bpos5 <= r_bpos4;
        r_oy5 <= r_oy4; r_dy5 <= r_dy4; r_cy5 <= r_cy4; r_h5 <= r_h4;

        o_item.a     <= r_a5;
        o_item.bmag  <= r_bmag5;
        o_item.b_pos <= r_bpos5;
        o_item.disc  <= n_disc;
        o_item.miss  <= (r_k2 >= r_ar2) || ({n_disc[125:0], 2'b00} < n_eps);
        o_item.oy    <= r_oy5;
        o_item.dy    <= r_dy5;
        o_item.cy    <= r_cy5;
        o_item.h     <= r_h5;
    end
endmodule

// ===== hw/rtl/rcci_fifo.sv =====
// Short queue between front and back end. Depends on rcci_pkg.
module rcci_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rcci_pkg::t_front_item i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output rcci_pkg::t_front_item o_data
);
    import rcci_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_front_item       r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop && o_valid) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop && o_valid);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hw/rtl/rcci_back.sv =====
// Back end: square root, root quotients, height tests and cap distance,
// fully pipelined one bit per stage. Depends on rcci_pkg.
module rcci_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rcci_pkg::t_front_item i_item,
    output logic                  o_valid,
    output rcci_pkg::t_result     o_res
);
    import rcci_pkg::*;

    localparam int EpsRaw = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int EpsT   = (EpsRaw > 0) ? EpsRaw : 1;
    localparam int SqS    = 63;   // root bits
    localparam int DvS    = 32;   // quotient steps incl. saturation check
    localparam int NW     = 66 + FRAC_BITS;

    // ---- square root pipeline, two radicand bits per stage ----
    t_front_item      r_sq_it [SqS+1];
    logic             r_sq_v  [SqS+1];
    logic [62:0]      r_sq_rt [SqS+1];
    logic [65:0]      r_sq_rm [SqS+1];

    always_comb begin
        r_sq_it[0] = i_item;
        r_sq_v[0]  = i_valid;
        r_sq_rt[0] = '0;
        r_sq_rm[0] = '0;
    end

    for (genvar g = 0; g < SqS; g++) begin : g_sq
        logic [65:0] rm, trial;
        logic        ge;
        // bring down the next two radicand bits, try (root << 2) | 1
        assign rm    = {r_sq_rm[g][63:0], r_sq_it[g].disc[125-2*g -: 2]};
        assign trial = {1'b0, r_sq_rt[g], 2'b01};
        assign ge    = rm >= trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[g+1] <= 1'b0;
            else          r_sq_v[g+1] <= r_sq_v[g];
            r_sq_it[g+1] <= r_sq_it[g];
            r_sq_rt[g+1] <= {r_sq_rt[g][61:0], ge};
            r_sq_rm[g+1] <= ge ? rm - trial : rm;
        end
    end

    // ---- numerator set-up ----
    t_front_item       r_nu_it;
    logic              r_nu_v, r_fok, r_nok;
    logic [NW-1:0]     r_nf, r_nn;
    logic [32:0]       r_cn;   // cap numerator magnitude
    logic              r_cpos;
    logic [31:0]       r_dym;
    logic [62:0]       s;
    logic signed [33:0] n_cap;

    always_comb begin
        s = r_sq_rt[SqS];
        n_cap = 34'(r_sq_it[SqS].cy) + 34'(r_sq_it[SqS].h) - 34'(r_sq_it[SqS].oy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nu_v <= 1'b0;
        else          r_nu_v <= r_sq_v[SqS];
        r_nu_it <= r_sq_it[SqS];
        if (!r_sq_it[SqS].b_pos) begin
            r_fok <= 1'b1;
            r_nf  <= NW'(66'(r_sq_it[SqS].bmag) + 66'(s)) << FRAC_BITS;
            r_nok <= r_sq_it[SqS].bmag > 65'(s);
            r_nn  <= NW'(r_sq_it[SqS].bmag - 65'(s)) << FRAC_BITS;
        end else begin
            r_fok <= 65'(s) > r_sq_it[SqS].bmag;
            r_nf  <= NW'(65'(s) - r_sq_it[SqS].bmag) << FRAC_BITS;
            r_nok <= 1'b0;
            r_nn  <= '0;
        end
        r_cpos <= (r_sq_it[SqS].dy < 0 && n_cap < 0) || (r_sq_it[SqS].dy > 0 && n_cap > 0);
        r_cn   <= 33'(n_cap[33] ? -n_cap : n_cap);
        r_dym  <= r_sq_it[SqS].dy[31] ? 32'(-r_sq_it[SqS].dy) : 32'(r_sq_it[SqS].dy);
    end

    // ---- three restoring dividers, one quotient bit per stage ----
    t_front_item   r_dv_it  [DvS+1];
    logic          r_dv_v   [DvS+1];
    logic          r_dv_fok [DvS+1];
    logic          r_dv_nok [DvS+1];
    logic          r_dv_cp  [DvS+1];
    logic [NW-1:0] r_rf [DvS+1], r_rn [DvS+1], r_rc [DvS+1];
    logic [30:0]   r_qf [DvS+1], r_qn [DvS+1], r_qc [DvS+1];
    logic          r_sf [DvS+1], r_sn [DvS+1], r_sc [DvS+1];
    logic [31:0]   r_dv_dy  [DvS+1];

    always_comb begin
        r_dv_it[0] = r_nu_it;  r_dv_v[0] = r_nu_v;
        r_dv_fok[0] = r_fok;   r_dv_nok[0] = r_nok; r_dv_cp[0] = r_cpos;
        r_rf[0] = r_nf; r_rn[0] = r_nn; r_rc[0] = NW'(r_cn) << FRAC_BITS;
        r_qf[0] = '0; r_qn[0] = '0; r_qc[0] = '0;
        r_sf[0] = 1'b0; r_sn[0] = 1'b0; r_sc[0] = 1'b0;
        r_dv_dy[0] = r_dym;
    end

    for (genvar g = 0; g < DvS; g++) begin : g_dv
        // step 0 checks saturation against den<<31, steps 1..31 give bits 30..0
        localparam int Sh = (g == 0) ? 31 : 31 - g;
        logic [NW+31:0] df, dc;
        logic gef, gen, gec;
        assign df  = (NW+32)'(r_dv_it[g].a) << Sh;
        assign dc  = (NW+32)'(r_dv_dy[g]) << Sh;
        assign gef = (NW+32)'(r_rf[g]) >= df;
        assign gen = (NW+32)'(r_rn[g]) >= df;
        assign gec = (NW+32)'(r_rc[g]) >= dc;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[g+1] <= 1'b0;
            else          r_dv_v[g+1] <= r_dv_v[g];
            r_dv_it[g+1] <= r_dv_it[g];
            r_dv_fok[g+1] <= r_dv_fok[g]; r_dv_nok[g+1] <= r_dv_nok[g];
            r_dv_cp[g+1] <= r_dv_cp[g];  r_dv_dy[g+1] <= r_dv_dy[g];
            if (g == 0) begin
                r_sf[g+1] <= gef; r_sn[g+1] <= gen; r_sc[g+1] <= gec;
                r_rf[g+1] <= r_rf[g]; r_rn[g+1] <= r_rn[g]; r_rc[g+1] <= r_rc[g];
                r_qf[g+1] <= '0; r_qn[g+1] <= '0; r_qc[g+1] <= '0;
            end else begin
                r_sf[g+1] <= r_sf[g]; r_sn[g+1] <= r_sn[g]; r_sc[g+1] <= r_sc[g];
                r_rf[g+1] <= gef ? NW'((NW+32)'(r_rf[g]) - df) : r_rf[g];
                r_rn[g+1] <= gen ? NW'((NW+32)'(r_rn[g]) - df) : r_rn[g];
                r_rc[g+1] <= gec ? NW'((NW+32)'(r_rc[g]) - dc) : r_rc[g];
                r_qf[g+1] <= r_qf[g] | (31'(gef) << (31 - g));
                r_qn[g+1] <= r_qn[g] | (31'(gen) << (31 - g));
                r_qc[g+1] <= r_qc[g] | (31'(gec) << (31 - g));
            end
        end
    end

    // ---- height products ----
    t_front_item        r_hp_it;
    logic               r_hp_v, r_hp_nok, r_hp_fok;
    logic [30:0]        r_tn, r_tf, r_tc;
    logic signed [64:0] r_y1p, r_y2p;
    logic [30:0]        tn, tf;

    always_comb begin
        tn = r_sn[DvS] ? 31'h7FFFFFFF : r_qn[DvS];
        tf = r_sf[DvS] ? 31'h7FFFFFFF : r_qf[DvS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hp_v <= 1'b0;
        else          r_hp_v <= r_dv_v[DvS];
        r_hp_it  <= r_dv_it[DvS];
        r_hp_nok <= r_dv_nok[DvS] && (tn >= 31'(EpsT));
        r_hp_fok <= r_dv_fok[DvS] && (tf >= 31'(EpsT));
        r_tn <= tn; r_tf <= tf;
        r_tc <= !r_dv_cp[DvS] ? '0 : (r_sc[DvS] ? 31'h7FFFFFFF : r_qc[DvS]);
        r_y1p <= 65'($signed({1'b0, tn}) * r_dv_it[DvS].dy);
        r_y2p <= 65'($signed({1'b0, tf}) * r_dv_it[DvS].dy);
    end

    // ---- decision ----
    logic signed [66:0] y1, y2, base, top;
    logic in1, in2, cap;

    always_comb begin
        y1   = (67'(r_hp_it.oy) <<< FRAC_BITS) + 67'(r_y1p);
        y2   = (67'(r_hp_it.oy) <<< FRAC_BITS) + 67'(r_y2p);
        base = 67'(r_hp_it.cy) <<< FRAC_BITS;
        top  = (67'(r_hp_it.cy) + 67'(r_hp_it.h)) <<< FRAC_BITS;
        cap  = r_hp_nok && (y1 > top) && (y2 < top) && (y2 >= base);
        in1  = r_hp_nok && (y1 <= top) && (y1 >= base);
        in2  = r_hp_fok && (y2 <= top) && (y2 >= base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_hp_v;
        if (r_hp_it.miss) begin
            o_res.hit <= 1'b0; o_res.distance <= '0;
        end else if (cap) begin
            o_res.hit <= 1'b1; o_res.distance <= r_tc;
        end else if (in1) begin
            o_res.hit <= 1'b1; o_res.distance <= r_tn;
        end else if (in2) begin
            o_res.hit <= 1'b1; o_res.distance <= r_tf;
        end else begin
            o_res.hit <= 1'b0; o_res.distance <= '0;
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.hit |-> o_res.distance == '0) else $error("miss with distance");
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hp_v |=> o_valid) else $error("result dropped");
    a_sat_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hp_nok |-> r_tn >= 31'(EpsT)) else $error("near root below epsilon");
endmodule

// ===== hw/rtl/ray_capped_cylinder_intersect.sv =====
// Ray versus y-axis capped cylinder intersection, top level.
// Depends on rcci_pkg, rcci_front, rcci_fifo, rcci_back.
//
// One ray is taken per cycle (busy stays low); each result appears on the
// o_hit / o_hit_distance ports for one cycle with o_done, after passing through
// the front end, the queue, the 63-step root pipeline and the 32-step
// quotient pipeline. The receiver cannot stall; results come
// out in order.
module ray_capped_cylinder_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic signed [31:0]   i_origin_z,
    input  logic signed [31:0]   i_dir_x,
    input  logic signed [31:0]   i_dir_y,
    input  logic signed [31:0]   i_dir_z,
    output logic                 o_done,
    output logic                 o_hit,
    output logic [30:0]          o_hit_distance,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [rcci_pkg::AddrW-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rcci_pkg::*;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad, r_hgt;
    logic [2:0]         idx;
    logic               wr;
    logic               f_v, q_v;
    t_front_item        f_it, q_it;
    t_result            res;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_cz <= '0;
            r_rad <= 31'h10000; r_hgt <= 31'h10000;
        end else if (wr) begin
            case (idx)
                REG_CENTER_X: r_cx  <= pwdata;
                REG_CENTER_Y: r_cy  <= pwdata;
                REG_CENTER_Z: r_cz  <= pwdata;
                REG_RADIUS:   r_rad <= pwdata[30:0];
                REG_HEIGHT:   r_hgt <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_CENTER_Z: prdata = r_cz;
            REG_RADIUS:   prdata = {1'b0, r_rad};
            REG_HEIGHT:   prdata = {1'b0, r_hgt};
            default:      prdata = '0;
        endcase
    end

    rcci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_ox(i_origin_x), .i_oy(i_origin_y), .i_oz(i_origin_z),
        .i_dx(i_dir_x), .i_dy(i_dir_y), .i_dz(i_dir_z),
        .i_cx(r_cx), .i_cy(r_cy), .i_cz(r_cz), .i_r(r_rad), .i_h(r_hgt),
        .o_valid(f_v), .o_item(f_it)
    );

    // back end never stalls, so pop whenever an item waits
    rcci_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_push(f_v), .i_data(f_it),
        .i_pop(q_v), .o_valid(q_v), .o_data(q_it)
    );

    rcci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .i_item(q_it),
        .o_valid(o_done), .o_res(res)
    );

    assign o_hit          = res.hit;
    assign o_hit_distance = res.distance;
endmodule

// ===== bench/ray_capped_cylinder_intersect_test.sv =====
// Self-checking bench for ray_capped_cylinder_intersect: rays in, hit / distance out.
// Depends on rcci_pkg and the block itself; builds its own cylinder-hit predictor.
`timescale 1ns / 1ps

module ray_capped_cylinder_intersect_test;
    import rcci_pkg::*;

    localparam int FB       = 16;
    localparam int EPS_T    = ((2 ** FB) + 500) / 1000;
    localparam int DRAIN    = 130;
    localparam int WD_LIMIT = 5000;
    localparam logic [30:0] T_MAX = 31'h7fff_ffff;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_done, o_hit;
    logic [30:0] o_hit_distance;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Cylinder as the predictor sees it
    logic signed [31:0] cyl_cx = 0, cyl_cy = 0, cyl_cz = 0;
    logic [30:0] cyl_r = 31'd65536, cyl_h = 31'd65536;

    t_result hits_due[$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;

    ray_capped_cylinder_intersect #(.FRAC_BITS(FB)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [30:0] div_sat(logic [191:0] n, logic [191:0] d);
        if (n >= (d << 31)) return T_MAX;
        return 31'(n / d);
    endfunction

    function automatic t_result cyl_hit(t_ray ray);
        logic signed [79:0] ox, oy, oz, dx, dy, dz, kk, bb, base, top, y1, y2, num, tn, tf;
        logic [191:0] a, bmag, kmag, ar2, k2, disc, s, c, nm, dm;
        logic n_ok, f_ok, b_pos;
        t_result r;
        r = '0;
        ox = ray.ox - cyl_cx;
        oz = ray.oz - cyl_cz;
        oy = ray.oy;
        dx = ray.dx;
        dy = ray.dy;
        dz = ray.dz;
        a = dx * dx + dz * dz;
        kk = dx * oz - dz * ox;
        kmag = (kk < 0) ? -kk : kk;
        bb = dx * ox + dz * oz;
        b_pos = bb > 0;
        bmag = (bb < 0) ? -bb : bb;
        ar2 = a * (cyl_r * cyl_r);
        k2 = kmag * kmag;
        if (k2 >= ar2) return r;
        disc = ar2 - k2;
        if ((disc << 2) < (192'(EPS_T) << (3 * FB))) return r;
        s = 0;
        for (int b = 63; b >= 0; b--) begin
            c = s | (192'd1 << b);
            if (c * c <= disc) s = c;
        end
        tn = 0;
        tf = 0;
        n_ok = 0;
        f_ok = 0;
        if (!b_pos) begin
            tf = div_sat((bmag + s) << FB, a);
            f_ok = 1;
            if (bmag > s) begin
                tn = div_sat((bmag - s) << FB, a);
                n_ok = 1;
            end
        end else if (s > bmag) begin
            tf = div_sat((s - bmag) << FB, a);
            f_ok = 1;
        end
        n_ok = n_ok && (tn >= EPS_T);
        f_ok = f_ok && (tf >= EPS_T);
        base = cyl_cy;
        top = base + $signed({1'b0, cyl_h});
        num = top - oy;
        base = base <<< FB;
        top = top <<< FB;
        y1 = (oy <<< FB) + tn * dy;
        y2 = (oy <<< FB) + tf * dy;
        if (n_ok && y1 > top && y2 < top && y2 >= base) begin
            // cap: distance from the origin up to the top plane
            r.hit = 1'b1;
            if ((dy < 0 && num < 0) || (dy > 0 && num > 0)) begin
                nm = (num < 0) ? -num : num;
                dm = (dy < 0) ? -dy : dy;
                r.distance = div_sat(nm << FB, dm);
            end
        end else if (n_ok && y1 <= top && y1 >= base) begin
            r.hit = 1'b1;
            r.distance = tn[30:0];
        end else if (f_ok && y2 <= top && y2 >= base) begin
            r.hit = 1'b1;
            r.distance = tf[30:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Predict on acceptance; check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_ray ray;
        t_result want;
        if (i_rst_n && start && !busy) begin
            ray = '{i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z};
            hits_due.push_back(cyl_hit(ray));
        end
        if (i_rst_n && o_done) begin
            if (hits_due.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = hits_due.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %b, want %b", o_hit, want.hit));
                if (o_hit_distance !== want.distance)
                    report_mismatch($sformatf("distance %h, want %h",
                                              o_hit_distance, want.distance));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(logic [2:0] code, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {code, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (code)
            REG_CENTER_X: cyl_cx = val;
            REG_CENTER_Y: cyl_cy = val;
            REG_CENTER_Z: cyl_cz = val;
            REG_RADIUS:   cyl_r = val[30:0];
            REG_HEIGHT:   cyl_h = val[30:0];
            default: ;
        endcase
    endtask

    // Stop sending, then wait for every outstanding item to come back
    task automatic wait_drained();
        start <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_cylinder(logic [31:0] cx, cy, cz, r, h);
        wait_drained();
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, r);
        reg_write(REG_HEIGHT, h);
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 19);
        if (no_gaps || roll < 12) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive at the current edge, hold until accepted, then maybe idle
    task automatic send_ray(t_ray ray);
        int gap;
        i_origin_x <= ray.ox;
        i_origin_y <= ray.oy;
        i_origin_z <= ray.oz;
        i_dir_x <= ray.dx;
        i_dir_y <= ray.dy;
        i_dir_z <= ray.dz;
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] fx(int whole, int frac = 0);
        return (whole <<< FB) + frac;
    endfunction

    function automatic logic signed [31:0] near_val(logic signed [31:0] c, int span);
        return c + $signed($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_ray wild_ray();
        return '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Ray starting near the cylinder and heading roughly across it
    function automatic t_ray aimed_ray();
        t_ray ray;
        int span;
        span = (cyl_r < 31'd1 << 20) ? 8 << FB : 1 << 24;
        ray.ox = near_val(cyl_cx, span);
        ray.oy = near_val(cyl_cy + $signed({1'b0, cyl_h[30:1]}), span);
        ray.oz = near_val(cyl_cz, span);
        ray.dx = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        ray.dy = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        ray.dz = $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        if ($urandom_range(0, 9) == 0) ray.dy = 0;
        if ($urandom_range(0, 9) == 0) ray.dx = 0;
        return ray;
    endfunction

    task automatic test_reset_cylinder();
        // vertical ray: no wall term at all
        send_ray('{0, fx(5), 0, 0, fx(-1), 0});
        // near wall, far wall from inside, top cap, passing over, zero direction
        send_ray('{fx(-3), fx(0, 32768), 0, fx(1), 0, 0});
        send_ray('{0, fx(0, 32768), 0, fx(1), 0, 0});
        send_ray('{fx(-3), fx(4), 0, fx(1), fx(-1), 0});
        send_ray('{fx(-3), fx(3), 0, fx(1), fx(-1), 0});
        send_ray('{fx(-3), fx(5), 0, fx(1), 0, 0});
        send_ray('{fx(-3), 0, 0, 0, 0, 0});
        // grazing the wall, and behind the origin
        send_ray('{fx(-3), fx(0, 100), fx(1), fx(1), 0, 0});
        send_ray('{fx(3), fx(0, 32768), 0, fx(1), 0, 0});
        // extremes of every field
        send_ray('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        send_ray('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
        send_ray('{32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 32'sh8000_0000});
        send_ray('{-1, -1, -1, 1, -1, 1});
        send_ray('{fx(-3), fx(0, 32768), 0, 1, 0, 0});
    endtask

    task automatic test_extreme_cylinders();
        set_cylinder(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        repeat (10) send_ray(wild_ray());
        repeat (10) send_ray(aimed_ray());
        set_cylinder(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
        repeat (10) send_ray(wild_ray());
        repeat (10) send_ray(aimed_ray());
        set_cylinder(0, 0, 0, 32'h0001_0000, 0);
        send_ray('{fx(-3), 0, 0, fx(1), 0, 0});
        repeat (10) send_ray(aimed_ray());
    endtask

    task automatic test_random_cylinders();
        logic [31:0] cx, cy, cz, r, h;
        for (int ph = 0; ph < 8; ph++) begin
            cx = $urandom_range(0, 2000 << FB) - (1000 << FB);
            cy = $urandom_range(0, 2000 << FB) - (1000 << FB);
            cz = $urandom_range(0, 2000 << FB) - (1000 << FB);
            r = $urandom_range(1 << 10, 6 << FB);
            h = $urandom_range(0, 6 << FB);
            if (ph == 7) begin
                r = $urandom & 32'h7fff_ffff;
                h = $urandom & 32'h7fff_ffff;
            end
            set_cylinder(cx, cy, cz, r, h);
            no_gaps = (ph % 3 == 1);
            for (int k = 0; k < 105; k++) begin
                if ($urandom_range(0, 9) < 7) send_ray(aimed_ray());
                else send_ray(wild_ray());
            end
        end
        no_gaps = 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_cylinder();
        set_cylinder(0, 0, 0, 32'h0001_0000, 32'h0001_0000);
        repeat (20) send_ray(aimed_ray());
        test_extreme_cylinders();
        test_random_cylinders();
        start <= 1'b0;
        wait_drained();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
